/* design/vrrq_pkg.sv */
// ----------------------------------------------------------------------------
// vrrq_pkg
// Shared constants and codes for the variable record ring queue.
// ----------------------------------------------------------------------------
package vrrq_pkg;

    // ring depth in bytes; a power of two so pointers wrap by truncation
    localparam int RING_BYTES = 1024;
    localparam int ADDR_W     = $clog2(RING_BYTES);
    localparam int FREE_W     = ADDR_W + 1;
    localparam int MAX_READ   = 64;
    localparam int HDR_BYTES  = 4;
    localparam int HDR_W      = 8 * HDR_BYTES;

    localparam int MODE_W  = 3;
    localparam int LEN_W   = 10;
    localparam int BYTE_W  = 8;
    localparam int LIM_W   = 7;
    localparam int STAT_W  = 2;
    localparam int OFREE_W = 11;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 3;

    localparam logic [MODE_W-1:0] MODE_PUSH_START = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BYTE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_OPEN = 2'd3;

endpackage

/* design/variable_record_ring_queue_unit.sv */
// ----------------------------------------------------------------------------
// variable_record_ring_queue_unit
// Byte ring queue of variable-length records with a 4-byte length header.
// ----------------------------------------------------------------------------
// One request is taken at a time. The ring sits in a single-port byte RAM
// with registered read data, and that port sets the timing. An accepted
// push_start writes four header bytes. pop and peek make four header reads,
// then pass a wait state and a length step, then return one byte per cycle
// while the output is taken. A finished result may wait in the output
// register, backed by a one-entry skid stage, while the next request is
// accepted. Reads of ring bytes never written since reset return undefined
// data.
module variable_record_ring_queue_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // record_length[9:0], data_byte[17:10], read_limit[24:18], zero pad
    input  logic [vrrq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // mode[2:0]
    input  logic [vrrq_pkg::MODE_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_byte[7:0], free_bytes[18:8], is_empty[19], zero pad
    output logic [vrrq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status[1:0], byte_valid[2]
    output logic [vrrq_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    output logic                                m_axis_tlast
);
    import vrrq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR_WR,
        ST_HDR_RD,
        ST_HDR_WAIT,
        ST_CALC,
        ST_EMIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [FREE_W-1:0] free;
        logic              empty;
    } entry_t;

    logic [BYTE_W-1:0] ring_mem [RING_BYTES];
    logic [BYTE_W-1:0] mem_q_reg;

    state_t            state_reg;
    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] tail_reg;
    logic [FREE_W-1:0] free_reg;
    logic [LEN_W-1:0]  pending_reg;
    logic [1:0]        cnt_reg;
    logic [LEN_W-1:0]  new_len_reg;
    logic [HDR_W-1:0]  len_reg;
    logic              hrd_valid_reg;
    logic [1:0]        hrd_sel_reg;
    logic              pop_reg;
    logic [LIM_W-1:0]  lim_reg;
    logic [LIM_W-1:0]  remain_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              rd_pending_reg;
    logic              rd_last_reg;
    logic [STAT_W-1:0] status_reg;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_bvalid_reg;
    entry_t            out_reg;
    logic              skid_valid_reg;
    entry_t            skid_reg;

    logic [MODE_W-1:0] in_mode;
    logic [LEN_W-1:0]  in_len;
    logic [BYTE_W-1:0] in_byte;
    logic [LIM_W-1:0]  in_lim;
    logic              in_accept;
    logic              out_pop;
    logic              out_free;
    logic [1:0]        occ;
    logic              issue;
    logic              resp_load;
    logic              is_empty;
    logic [LEN_W:0]    need;
    logic [HDR_W-1:0]  hdr_word;
    logic [HDR_W:0]    nf;
    logic [ADDR_W-1:0] pos;
    logic [ADDR_W-1:0] head_after;
    logic [LIM_W-1:0]  n_bytes;
    entry_t            incoming;

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_wdata;

    assign in_len  = s_axis_tdata[LEN_W-1:0];
    assign in_byte = s_axis_tdata[LEN_W+BYTE_W-1:LEN_W];
    assign in_lim  = s_axis_tdata[LEN_W+BYTE_W+LIM_W-1:LEN_W+BYTE_W];
    assign in_mode = s_axis_tuser;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = out_valid_reg && m_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign is_empty      = (free_reg == FREE_W'(RING_BYTES));

    assign occ = 2'(out_valid_reg) + 2'(skid_valid_reg) + 2'(rd_pending_reg)
               - 2'(out_pop);
    assign issue     = (state_reg == ST_EMIT) && (occ <= 2'd1);
    assign resp_load = (state_reg == ST_RESP) && out_free && !skid_valid_reg
                       && !rd_pending_reg;

    assign need       = (LEN_W+1)'(in_len) + (LEN_W+1)'(HDR_BYTES);
    assign hdr_word   = HDR_W'(new_len_reg);
    assign nf         = (HDR_W+1)'(free_reg) + (HDR_W+1)'(HDR_BYTES)
                      + (HDR_W+1)'(len_reg);
    assign pos        = head_reg + ADDR_W'(HDR_BYTES);
    assign head_after = pos + len_reg[ADDR_W-1:0];
    assign n_bytes    = (len_reg < HDR_W'(lim_reg)) ? len_reg[LIM_W-1:0] : lim_reg;

    assign incoming.data  = mem_q_reg;
    assign incoming.last  = rd_last_reg;
    assign incoming.free  = free_reg;
    assign incoming.empty = is_empty;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = tail_reg;
        mem_wdata = in_byte;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_we = in_accept && (in_mode == MODE_PUSH_BYTE)
                         && (pending_reg != '0);
            end
            ST_HDR_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = hdr_word[8*cnt_reg +: 8];
            end
            ST_HDR_RD:
            begin
                mem_re   = 1'b1;
                mem_addr = head_reg + ADDR_W'(cnt_reg);
            end
            ST_EMIT:
            begin
                mem_re   = issue;
                mem_addr = rd_addr_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= ring_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            free_reg       <= FREE_W'(RING_BYTES);
            pending_reg    <= '0;
            cnt_reg        <= '0;
            new_len_reg    <= '0;
            len_reg        <= '0;
            hrd_valid_reg  <= 1'b0;
            hrd_sel_reg    <= '0;
            pop_reg        <= 1'b0;
            lim_reg        <= '0;
            remain_reg     <= '0;
            rd_addr_reg    <= '0;
            rd_pending_reg <= 1'b0;
            rd_last_reg    <= 1'b0;
            status_reg     <= STAT_OK;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_OK;
            out_bvalid_reg <= 1'b0;
            out_reg        <= '0;
            skid_valid_reg <= 1'b0;
            skid_reg       <= '0;
        end
        else
        begin
            // header byte capture, in the cycle after each read
            hrd_valid_reg <= (state_reg == ST_HDR_RD);
            hrd_sel_reg   <= cnt_reg;
            if (hrd_valid_reg)
            begin
                len_reg[8*hrd_sel_reg +: 8] <= mem_q_reg;
            end

            rd_pending_reg <= issue;
            if (issue)
            begin
                rd_last_reg <= (remain_reg == LIM_W'(1));
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        unique case (in_mode)
                            MODE_PUSH_START:
                            begin
                                if ((LEN_W+2)'(free_reg) < (LEN_W+2)'(need))
                                begin
                                    status_reg <= STAT_FULL;
                                    state_reg  <= ST_RESP;
                                end
                                else
                                begin
                                    status_reg  <= STAT_OK;
                                    tail_reg    <= tail_reg + pending_reg[ADDR_W-1:0];
                                    free_reg    <= FREE_W'(free_reg - FREE_W'(need));
                                    pending_reg <= in_len;
                                    new_len_reg <= in_len;
                                    cnt_reg     <= '0;
                                    state_reg   <= ST_HDR_WR;
                                end
                            end
                            MODE_PUSH_BYTE:
                            begin
                                state_reg <= ST_RESP;
                                if (pending_reg == '0)
                                begin
                                    status_reg <= STAT_NO_OPEN;
                                end
                                else
                                begin
                                    status_reg  <= STAT_OK;
                                    tail_reg    <= tail_reg + ADDR_W'(1);
                                    pending_reg <= pending_reg - LEN_W'(1);
                                end
                            end
                            MODE_POP, MODE_PEEK:
                            begin
                                if (is_empty)
                                begin
                                    status_reg <= STAT_EMPTY;
                                    state_reg  <= ST_RESP;
                                end
                                else
                                begin
                                    status_reg <= STAT_OK;
                                    pop_reg    <= (in_mode == MODE_POP);
                                    lim_reg    <= (in_lim > LIM_W'(MAX_READ))
                                                  ? LIM_W'(MAX_READ) : in_lim;
                                    cnt_reg    <= '0;
                                    state_reg  <= ST_HDR_RD;
                                end
                            end
                            MODE_CLEAR:
                            begin
                                status_reg  <= STAT_OK;
                                state_reg   <= ST_RESP;
                                tail_reg    <= head_reg;
                                free_reg    <= FREE_W'(RING_BYTES);
                                pending_reg <= '0;
                            end
                            default:
                            begin
                                status_reg <= STAT_OK;
                                state_reg  <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_HDR_WR:
                begin
                    tail_reg <= tail_reg + ADDR_W'(1);
                    cnt_reg  <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'(HDR_BYTES - 1))
                    begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_HDR_RD:
                begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'(HDR_BYTES - 1))
                    begin
                        state_reg <= ST_HDR_WAIT;
                    end
                end
                ST_HDR_WAIT:
                begin
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    if (pop_reg)
                    begin
                        head_reg <= head_after;
                        if (nf >= (HDR_W+1)'(RING_BYTES))
                        begin
                            free_reg    <= FREE_W'(RING_BYTES);
                            pending_reg <= '0;
                            tail_reg    <= head_after;
                        end
                        else
                        begin
                            free_reg <= nf[FREE_W-1:0];
                        end
                    end
                    rd_addr_reg <= pos;
                    remain_reg  <= n_bytes;
                    state_reg   <= (n_bytes == '0) ? ST_RESP : ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (issue)
                    begin
                        rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                        remain_reg  <= remain_reg - LIM_W'(1);
                        if (remain_reg == LIM_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_RESP:
                begin
                    if (resp_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // output register with one skid entry
            if (resp_load)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= status_reg;
                out_bvalid_reg <= 1'b0;
                out_reg.data   <= '0;
                out_reg.last   <= 1'b1;
                out_reg.free   <= free_reg;
                out_reg.empty  <= is_empty;
            end
            else if (out_free)
            begin
                out_status_reg <= STAT_OK;
                out_bvalid_reg <= 1'b1;
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_reg        <= skid_reg;
                    skid_valid_reg <= rd_pending_reg;
                    skid_reg       <= incoming;
                end
                else if (rd_pending_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_reg       <= incoming;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (rd_pending_reg)
            begin
                skid_valid_reg <= 1'b1;
                skid_reg       <= incoming;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tuser  = {out_bvalid_reg, out_status_reg};
    assign m_axis_tdata  = {(OUT_DATA_W-BYTE_W-OFREE_W-1)'(0), out_reg.empty,
                            OFREE_W'(out_reg.free), out_reg.data};

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the variable record ring queue. A directed table
// covers the empty, full and no-open-record cases, the read cap and records
// reopened while still being filled. Random record traffic follows. Every
// result is compared with an in-bench model of the byte ring or with the
// value in the directed table, and both stream ports stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import vrrq_pkg::*;

    localparam int N_DIRECTED   = 27;
    localparam int RANDOM_ITEMS = 185;
    localparam int MAX_GAP      = 17;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_PRINTS   = 200;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last;
        logic [OFREE_W-1:0] free_bytes;
        logic               is_empty;
    } ring_result_t;

    typedef struct {
        logic [MODE_W-1:0] mode;
        int                len;
        int                dbyte;
        int                lim;
        bit                typed;
        logic [STAT_W-1:0] stat;
        int                free;
        bit                empty;
    } request_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [MODE_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    // ring model
    logic [7:0]   ring_mem     [RING_BYTES];
    bit           ring_written [RING_BYTES];
    int           rd_ptr;
    int           wr_ptr;
    int           free_space;
    int           owed_bytes;

    ring_result_t step_out[$];
    ring_result_t expected_results[$];
    ring_result_t oldest;

    int n_items;
    int n_ignored;
    int n_byte_results;
    int n_full;
    int n_empty_reads;
    int n_errors;
    bit send_fast;

    request_row_t directed_rows [N_DIRECTED] = '{
        '{MODE_POP,        0,    'h00,  5, 1'b1, STAT_EMPTY,   1024, 1'b1},
        '{MODE_PEEK,       0,    'h00,  0, 1'b1, STAT_EMPTY,   1024, 1'b1},
        '{MODE_PUSH_BYTE,  0,    'hAA,  0, 1'b1, STAT_NO_OPEN, 1024, 1'b1},
        '{MODE_PUSH_START, 3,    'h00,  0, 1'b1, STAT_OK,      1017, 1'b0},
        '{MODE_PUSH_BYTE,  0,    'hFF,  0, 1'b1, STAT_OK,      1017, 1'b0},
        '{MODE_PUSH_BYTE,  0,    'h00,  0, 1'b1, STAT_OK,      1017, 1'b0},
        '{MODE_PUSH_BYTE,  0,    'h5A,  0, 1'b1, STAT_OK,      1017, 1'b0},
        '{MODE_PUSH_BYTE,  0,    'h11,  0, 1'b1, STAT_NO_OPEN, 1017, 1'b0},
        '{MODE_PEEK,       0,    'h00, 64, 1'b0, STAT_OK,      0,    1'b0},
        '{MODE_PEEK,       0,    'h00,  2, 1'b0, STAT_OK,      0,    1'b0},
        '{MODE_PUSH_START, 0,    'h00,  0, 1'b1, STAT_OK,      1013, 1'b0},
        '{MODE_PEEK,       0,    'h00, 127, 1'b0, STAT_OK,     0,    1'b0},
        '{MODE_POP,        0,    'h00,  1, 1'b0, STAT_OK,      0,    1'b0},
        '{MODE_POP,        0,    'h00, 10, 1'b1, STAT_OK,      1024, 1'b1},
        '{MODE_PUSH_START, 1020, 'h00,  0, 1'b1, STAT_OK,      0,    1'b0},
        '{MODE_PUSH_START, 0,    'h00,  0, 1'b1, STAT_FULL,    0,    1'b0},
        '{MODE_PUSH_BYTE,  0,    'h80,  0, 1'b1, STAT_OK,      0,    1'b0},
        '{MODE_PEEK,       0,    'h00, 64, 1'b0, STAT_OK,      0,    1'b0},
        '{MODE_CLEAR,      0,    'h00,  0, 1'b1, STAT_OK,      1024, 1'b1},
        '{MODE_UNUSED,     0,    'h00,  0, 1'b1, STAT_OK,      1024, 1'b1},
        '{MODE_PUSH_START, 10,   'h00,  0, 1'b1, STAT_OK,      1010, 1'b0},
        '{MODE_PUSH_BYTE,  0,    'h01,  0, 1'b1, STAT_OK,      1010, 1'b0},
        '{MODE_PUSH_START, 2,    'h00,  0, 1'b1, STAT_OK,      1004, 1'b0},
        '{MODE_PUSH_BYTE,  0,    'h7E,  0, 1'b1, STAT_OK,      1004, 1'b0},
        '{MODE_PUSH_BYTE,  0,    'h81,  0, 1'b1, STAT_OK,      1004, 1'b0},
        '{MODE_POP,        0,    'h00, 64, 1'b0, STAT_OK,      0,    1'b0},
        '{MODE_POP,        0,    'h00, 64, 1'b0, STAT_OK,      0,    1'b0}
    };

    variable_record_ring_queue_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int header_len(int pos);
        int len;
        int i;
        len = 0;
        for (i = 0; i < HDR_BYTES; i++)
            len = len | (int'(ring_mem[(pos + i) % RING_BYTES]) << (8 * i));
        return len;
    endfunction

    function automatic void add_result(logic [STAT_W-1:0] st, logic [BYTE_W-1:0] b,
                                       logic v, logic l);
        step_out.push_back('{st, b, v, l, OFREE_W'(free_space), free_space == RING_BYTES});
    endfunction

    // never read ring bytes that have not been written since reset
    function automatic int clamp_read_limit(int lim);
        int want;
        int pos;
        int i;
        if (free_space >= RING_BYTES)
            return lim;
        want = (lim < MAX_READ) ? lim : MAX_READ;
        if (header_len(rd_ptr) < want)
            want = header_len(rd_ptr);
        pos = (rd_ptr + HDR_BYTES) % RING_BYTES;
        for (i = 0; i < want; i++)
            if (!ring_written[(pos + i) % RING_BYTES])
                return i;
        return lim;
    endfunction

    task automatic predict_request(logic [MODE_W-1:0] mode, int len, int dbyte, int lim);
        int rec_len;
        int n;
        int pos;
        int i;
        step_out.delete();
        case (mode)
            MODE_PUSH_START:
            begin
                if (free_space < len + HDR_BYTES)
                    add_result(STAT_FULL, 8'h00, 1'b0, 1'b1);
                else
                begin
                    wr_ptr = (wr_ptr + owed_bytes) % RING_BYTES;
                    free_space = free_space - len - HDR_BYTES;
                    for (i = 0; i < HDR_BYTES; i++)
                    begin
                        ring_mem[wr_ptr] = 8'(len >> (8 * i));
                        ring_written[wr_ptr] = 1'b1;
                        wr_ptr = (wr_ptr + 1) % RING_BYTES;
                    end
                    owed_bytes = len;
                    add_result(STAT_OK, 8'h00, 1'b0, 1'b1);
                end
            end
            MODE_PUSH_BYTE:
            begin
                if (owed_bytes == 0)
                    add_result(STAT_NO_OPEN, 8'h00, 1'b0, 1'b1);
                else
                begin
                    ring_mem[wr_ptr] = 8'(dbyte);
                    ring_written[wr_ptr] = 1'b1;
                    wr_ptr = (wr_ptr + 1) % RING_BYTES;
                    owed_bytes--;
                    add_result(STAT_OK, 8'h00, 1'b0, 1'b1);
                end
            end
            MODE_POP, MODE_PEEK:
            begin
                if (free_space >= RING_BYTES)
                    add_result(STAT_EMPTY, 8'h00, 1'b0, 1'b1);
                else
                begin
                    rec_len = header_len(rd_ptr);
                    n = (lim < MAX_READ) ? lim : MAX_READ;
                    if (rec_len < n)
                        n = rec_len;
                    pos = (rd_ptr + HDR_BYTES) % RING_BYTES;
                    if (mode == MODE_POP)
                    begin
                        rd_ptr = (pos + rec_len) % RING_BYTES;
                        if (free_space + HDR_BYTES + rec_len >= RING_BYTES)
                        begin
                            free_space = RING_BYTES;
                            owed_bytes = 0;
                            wr_ptr = rd_ptr;
                        end
                        else
                            free_space = free_space + HDR_BYTES + rec_len;
                    end
                    if (n == 0)
                        add_result(STAT_OK, 8'h00, 1'b0, 1'b1);
                    else
                        for (i = 0; i < n; i++)
                            add_result(STAT_OK, ring_mem[(pos + i) % RING_BYTES], 1'b1,
                                       i + 1 == n);
                end
            end
            MODE_CLEAR:
            begin
                wr_ptr = rd_ptr;
                free_space = RING_BYTES;
                owed_bytes = 0;
                add_result(STAT_OK, 8'h00, 1'b0, 1'b1);
            end
            default:
                add_result(STAT_OK, 8'h00, 1'b0, 1'b1);
        endcase
    endtask

    // drive one request, predict on acceptance; typed rows replace the prediction
    task automatic send_request(logic [MODE_W-1:0] mode, int len, int dbyte, int lim,
                                bit typed, logic [STAT_W-1:0] tstat, int tfree,
                                bit tempty);
        int gap;
        int sent_lim;
        gap = send_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sent_lim = (mode == MODE_POP || mode == MODE_PEEK) ? clamp_read_limit(lim) : lim;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, 7'(sent_lim), 8'(dbyte), 10'(len)};
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_request(mode, len, dbyte, sent_lim);
        if (typed)
            expected_results.push_back('{tstat, 8'h00, 1'b0, 1'b1, OFREE_W'(tfree), tempty});
        else
            foreach (step_out[i])
                expected_results.push_back(step_out[i]);
        foreach (step_out[i])
            if (step_out[i].byte_valid)
                n_byte_results++;
        n_items++;
        if (step_out[0].status == STAT_NO_OPEN)
            n_ignored++;
        if (step_out[0].status == STAT_FULL)
            n_full++;
        if (step_out[0].status == STAT_EMPTY)
            n_empty_reads++;
        if ($urandom_range(0, 39) == 0)
            send_fast = !send_fast;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 32'(m_axis_tdata), 32'd0);
            else
            begin
                oldest = expected_results.pop_front();
                if (m_axis_tuser[1:0] !== oldest.status)
                    report_mismatch("status", 32'(m_axis_tuser[1:0]), 32'(oldest.status));
                if (m_axis_tdata[7:0] !== oldest.out_byte)
                    report_mismatch("out_byte", 32'(m_axis_tdata[7:0]),
                                    32'(oldest.out_byte));
                if (m_axis_tuser[2] !== oldest.byte_valid)
                    report_mismatch("byte_valid", 32'(m_axis_tuser[2]),
                                    32'(oldest.byte_valid));
                if (m_axis_tlast !== oldest.last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(oldest.last));
                if (m_axis_tdata[18:8] !== oldest.free_bytes)
                    report_mismatch("free_bytes", 32'(m_axis_tdata[18:8]),
                                    32'(oldest.free_bytes));
                if (m_axis_tdata[19] !== oldest.is_empty)
                    report_mismatch("is_empty", 32'(m_axis_tdata[19]),
                                    32'(oldest.is_empty));
            end
        end
    end

    initial
    begin : result_sink
        int stall;
        bit sink_fast;
        sink_fast = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_fast = !sink_fast;
            stall = sink_fast ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int  len;
        int  fill;
        int  pick;
        bit  pressure_done;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_PUSH_START;
        rd_ptr        = 0;
        wr_ptr        = 0;
        free_space    = RING_BYTES;
        owed_bytes    = 0;
        send_fast     = 1'b0;
        pressure_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_request(directed_rows[r].mode, directed_rows[r].len,
                         directed_rows[r].dbyte, directed_rows[r].lim,
                         directed_rows[r].typed, directed_rows[r].stat,
                         directed_rows[r].free, directed_rows[r].empty);

        while (n_items < N_DIRECTED + RANDOM_ITEMS)
        begin
            if (!pressure_done && n_items >= N_DIRECTED + RANDOM_ITEMS / 2)
            begin
                // hold off until the queue has answered everything
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (expected_results.size() != 0)
                    @(posedge clk);
                pressure_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1020)
                                                  : $urandom_range(0, 16);
                send_request(MODE_PUSH_START, len, $urandom_range(0, 255),
                             $urandom_range(0, MAX_READ), 0, STAT_OK, 0, 0);
                if (step_out[0].status == STAT_OK)
                begin
                    if (len > 32)
                        fill = $urandom_range(0, 32);
                    else
                        fill = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len;
                    repeat (fill)
                        send_request(MODE_PUSH_BYTE, $urandom_range(0, 1020),
                                     $urandom_range(0, 255), $urandom_range(0, MAX_READ),
                                     0, STAT_OK, 0, 0);
                end
            end
            else if (pick < 80)
                send_request(($urandom_range(0, 1) == 0) ? MODE_POP : MODE_PEEK,
                             $urandom_range(0, 1020), $urandom_range(0, 255),
                             ($urandom_range(0, 3) == 0) ? MAX_READ
                                                         : $urandom_range(0, MAX_READ),
                             0, STAT_OK, 0, 0);
            else if (pick < 85)
                send_request(MODE_CLEAR, $urandom_range(0, 1020), $urandom_range(0, 255),
                             $urandom_range(0, MAX_READ), 0, STAT_OK, 0, 0);
            else if (pick < 93)
                send_request(MODE_PUSH_BYTE, $urandom_range(0, 1020), $urandom_range(0, 255),
                             $urandom_range(0, MAX_READ), 0, STAT_OK, 0, 0);
            else
                send_request(MODE_PUSH_START, $urandom_range(0, 16), $urandom_range(0, 255),
                             $urandom_range(0, MAX_READ), 0, STAT_OK, 0, 0);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests answered: %0d, ignored push bytes: %0d, bytes read back: %0d",
                 n_items, n_ignored, n_byte_results);
        $display("full rejects: %0d, reads of an empty queue: %0d, mismatches: %0d",
                 n_full, n_empty_reads, n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
